[src/htfd_pkg.sv]
// Shared types, constants and the CRC-8 byte function for the reply frame decoder.
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scaling factors and offset for the centi-unit conversions.
    localparam int TEMP_SCALE  = 17500;
    localparam int HUM_SCALE   = 10000;
    localparam int TEMP_OFFSET = 4500;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    typedef enum logic [2:0] {
        POS_TEMP_MSB = 3'd0,
        POS_TEMP_LSB = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUM_MSB  = 3'd3,
        POS_HUM_LSB  = 3'd4,
        POS_HUM_CRC  = 3'd5
    } byte_pos_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } check_status_t;

    // CRC-8, MSB first, one whole byte per call.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/humidity_temp_frame_decoder.sv]
// Top level of the six-byte humidity and temperature reply decoder.
// Throughput: one byte per cycle; the input register, the product register and
// the output register each advance whenever the stage behind them is free.
// Reset (aresetn low, synchronous) empties all stages, sets the byte position
// to zero, the CRC accumulator to 0xFF and clears the assembled words.
module humidity_temp_frame_decoder import htfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] reply_byte
    input  logic        s_tuser,  // [0] frame_begin
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi, [44:29] raw_temperature,
    // [60:45] raw_humidity, [62:61] check_status, [63] zero
    output logic [63:0] m_tdata
);

    // Input register
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_begin_reg;

    // Frame state
    byte_pos_t  pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0] hum_high_reg, hum_high_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic       temp_bad_reg, temp_bad_next;

    // Product register
    logic                    b_valid_reg, b_valid_next;
    logic [TEMP_PROD_W-1:0]  b_prod_t_reg;
    logic [HUM_PROD_W-1:0]   b_prod_h_reg;
    logic [15:0]             b_raw_t_reg;
    logic [15:0]             b_raw_h_reg;
    check_status_t           b_status_reg, status_next;

    // Output register
    logic                     m_valid_reg;
    logic [63:0]              m_data_reg;

    logic out_en, b_en, a_en;
    byte_pos_t pos_cur;
    logic [TEMP_PROD_W-17:0] t_quot;
    logic [HUM_PROD_W-17:0]  h_quot;
    logic [14:0]             t_centi;

    assign out_en   = !m_valid_reg || m_tready;
    assign b_en     = !b_valid_reg || out_en;
    assign a_en     = !a_valid_reg || b_en;
    assign s_tready = a_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= s_tvalid;
        end
        if (a_en) begin
            a_byte_reg  <= s_tdata;
            a_begin_reg <= s_tuser;
        end
    end

    always_comb begin
        pos_cur        = a_begin_reg ? POS_TEMP_MSB : pos_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_high_next  = hum_high_reg;
        hum_word_next  = hum_word_reg;
        temp_bad_next  = temp_bad_reg;
        b_valid_next   = 1'b0;
        status_next    = STATUS_OK;
        unique case (pos_cur)
            POS_TEMP_MSB: begin
                temp_word_next = {a_byte_reg, 8'h00};
                crc_next       = crc8_byte(CRC_INIT, a_byte_reg);
                pos_next       = POS_TEMP_LSB;
            end
            POS_TEMP_LSB: begin
                temp_word_next = {temp_word_reg[15:8], a_byte_reg};
                crc_next       = crc8_byte(crc_reg, a_byte_reg);
                pos_next       = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
                temp_bad_next = (crc_reg != a_byte_reg);
                crc_next      = CRC_INIT;
                pos_next      = POS_HUM_MSB;
            end
            POS_HUM_MSB: begin
                hum_high_next = a_byte_reg;
                crc_next      = crc8_byte(CRC_INIT, a_byte_reg);
                pos_next      = POS_HUM_LSB;
            end
            POS_HUM_LSB: begin
                hum_word_next = {hum_high_reg, a_byte_reg};
                crc_next      = crc8_byte(crc_reg, a_byte_reg);
                pos_next      = POS_HUM_CRC;
            end
            POS_HUM_CRC: begin
                // Temperature takes precedence when both checks fail.
                if (temp_bad_reg) begin
                    status_next = STATUS_TEMP_BAD;
                end else if (crc_reg != a_byte_reg) begin
                    status_next = STATUS_HUM_BAD;
                end else begin
                    status_next = STATUS_OK;
                end
                b_valid_next = 1'b1;
                crc_next     = CRC_INIT;
                pos_next     = POS_TEMP_MSB;
            end
            default: begin
                pos_next = POS_TEMP_MSB;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_TEMP_MSB;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= 16'd0;
            hum_high_reg  <= 8'd0;
            hum_word_reg  <= 16'd0;
            temp_bad_reg  <= 1'b0;
        end else if (a_valid_reg && b_en) begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_high_reg  <= hum_high_next;
            hum_word_reg  <= hum_word_next;
            temp_bad_reg  <= temp_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_en) begin
            b_valid_reg <= a_valid_reg && b_valid_next;
        end
        if (b_en) begin
            b_prod_t_reg <= TEMP_PROD_W'(temp_word_reg * TEMP_PROD_W'(TEMP_SCALE));
            b_prod_h_reg <= HUM_PROD_W'(hum_word_reg * HUM_PROD_W'(HUM_SCALE));
            b_raw_t_reg  <= temp_word_reg;
            b_raw_h_reg  <= hum_word_reg;
            b_status_reg <= status_next;
        end
    end

    htfd_div65535 #(.PROD_W(TEMP_PROD_W)) u_div_temp (
        .prod (b_prod_t_reg),
        .quot (t_quot)
    );

    htfd_div65535 #(.PROD_W(HUM_PROD_W)) u_div_hum (
        .prod (b_prod_h_reg),
        .quot (h_quot)
    );

    assign t_centi = t_quot - 15'(TEMP_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= b_valid_reg;
        end
        if (out_en) begin
            m_data_reg <= {1'b0, b_status_reg, b_raw_h_reg, b_raw_t_reg, h_quot, t_centi};
        end
    end

endmodule

[src/htfd_div65535.sv]
// Floor division of a registered product by 65535 using a shift and one correction step.
module htfd_div65535 import htfd_pkg::*; #(
    parameter int PROD_W = TEMP_PROD_W
) (
    input  logic [PROD_W-1:0]  prod,
    output logic [PROD_W-17:0] quot
);

    localparam int Q_W = PROD_W - 16;

    logic [Q_W-1:0] q0;
    logic [16:0]    rem;

    // The remainder against 65535 is the low half plus the high half; it stays
    // below twice the divisor, so a single compare settles the quotient.
    assign q0   = prod[PROD_W-1:16];
    assign rem  = {1'b0, prod[15:0]} + {{(17-Q_W){1'b0}}, q0};
    assign quot = (rem >= 17'd65535) ? q0 + {{(Q_W-1){1'b0}}, 1'b1} : q0;

endmodule

[src/htfd_checker.sv]
// Port-level assertions for the reply frame decoder, bound to the top level.
module htfd_checker import htfd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A result that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The output stage is empty after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // Status never takes the unused code and the padding bit stays clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[62:61] <= STATUS_HUM_BAD) && !m_tdata[63])
        else $error("illegal status or padding in result");

    // Humidity never exceeds one hundred percent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
        else $error("humidity out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
